[rtl/cpos_pkg.sv]
// ----------------------------------------------------------------------------
// cpos_pkg: shared types and codes for the closest point on segment unit
// Holds the clamp code type and its named values.
// ----------------------------------------------------------------------------
package cpos_pkg;

   typedef logic [1:0] code_type;

   // where the result landed on the segment
   localparam code_type CLAMP_NONE  = 2'd0;
   localparam code_type CLAMP_START = 2'd1;
   localparam code_type CLAMP_END   = 2'd2;

endpackage

[rtl/cpos_div.sv]
// ----------------------------------------------------------------------------
// cpos_div: pipelined unsigned restoring divider
// One quotient bit per register stage, QUOT_WIDTH stages, a new word every
// cycle. The caller guarantees the quotient fits in QUOT_WIDTH bits.
// A side word travels alongside each quotient.
// ----------------------------------------------------------------------------
module cpos_div #(
   parameter int NUM_WIDTH  = 65,
   parameter int DEN_WIDTH  = 43,
   parameter int QUOT_WIDTH = 20,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [NUM_WIDTH-1:0]  numer,
   input  logic [DEN_WIDTH-1:0]  denom,
   input  logic [SIDE_WIDTH-1:0] side_in,
   output logic                  out_valid,
   output logic [QUOT_WIDTH-1:0] quot,
   output logic [SIDE_WIDTH-1:0] side_out
);

   logic                  vld_ff  [QUOT_WIDTH];
   logic [NUM_WIDTH-1:0]  rem_ff  [QUOT_WIDTH];
   logic [DEN_WIDTH-1:0]  den_ff  [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] q_ff    [QUOT_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff [QUOT_WIDTH];

   genvar k;
   generate
      for (k = 0; k < QUOT_WIDTH; k++) begin : g_stage
         logic                  vld_src;
         logic [NUM_WIDTH-1:0]  rem_src;
         logic [DEN_WIDTH-1:0]  den_src;
         logic [QUOT_WIDTH-1:0] q_src;
         logic [SIDE_WIDTH-1:0] side_src;
         logic [NUM_WIDTH-1:0]  trial;
         logic                  fits;
         logic [NUM_WIDTH-1:0]  rem_in;
         logic [QUOT_WIDTH-1:0] q_in;

         // pick the previous stage, or the ports for the first one
         if (k == 0) begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = numer;
            assign den_src  = denom;
            assign q_src    = '0;
            assign side_src = side_in;
         end else begin : g_next
            assign vld_src  = vld_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign den_src  = den_ff[k-1];
            assign q_src    = q_ff[k-1];
            assign side_src = side_ff[k-1];
         end

         // try the shifted divisor, keep the bit if it fits
         assign trial  = {{(NUM_WIDTH-DEN_WIDTH){1'b0}}, den_src} << (QUOT_WIDTH-1-k);
         assign fits   = (rem_src >= trial);
         assign rem_in = fits ? (rem_src - trial) : rem_src;
         assign q_in   = q_src | ({{(QUOT_WIDTH-1){1'b0}}, fits} << (QUOT_WIDTH-1-k));

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src;
            end
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_src;
         end
      end
   endgenerate

   assign out_valid = vld_ff[QUOT_WIDTH-1];
   assign quot      = q_ff[QUOT_WIDTH-1];
   assign side_out  = side_ff[QUOT_WIDTH-1];

endmodule

[rtl/closest_point_on_segment_unit.sv]
// ----------------------------------------------------------------------------
// closest_point_on_segment_unit: nearest point on a segment to a query point
// A query is taken in any cycle that start is high; busy stays low, so one
// word per cycle is sustained. Each result appears as one rsp_strobe cycle,
// in query order, after the difference, product, sum, clamp and split stages,
// the divider and the output register; the receiver cannot stall it. The
// divider resolves one quotient bit per stage. A zero-length segment
// returns its start point with zero_length set and clamp_code zero.
// ----------------------------------------------------------------------------
module closest_point_on_segment_unit #(
   parameter int COORD_WIDTH = 20,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_query_x,
   input  logic signed [COORD_WIDTH-1:0] req_query_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_near_x,
   output logic signed [COORD_WIDTH-1:0] rsp_near_y,
   output cpos_pkg::code_type            rsp_clamp_code,
   output logic                          rsp_zero_length
);

   // the binary point sits at FRAC_BITS but the arithmetic does not depend on it
   localparam int CW = COORD_WIDTH + 0 * FRAC_BITS;
   localparam int DW = CW + 1;        // coordinate difference
   localparam int PW = 2 * DW;        // one product of differences
   localparam int LW = PW + 1;        // length squared and dot product
   localparam int MW = LW + DW;       // numerator terms
   localparam int NW = MW + 1;        // numerator sum
   localparam int SW = 1 + 1 + CW + 2 + 1; // x side: use, neg, alt, code, zero
   localparam int TW = 1 + CW;             // y side: neg, alt

   assign busy = 1'b0;

   // stage 1: differences
   logic              v1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, ax1_ff, ay1_ff;
   logic signed [CW-1:0] sx1_ff, sy1_ff, ex1_ff, ey1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      dx1_ff <= DW'(req_seg_end_x) - DW'(req_seg_start_x);
      dy1_ff <= DW'(req_seg_end_y) - DW'(req_seg_start_y);
      ax1_ff <= DW'(req_query_x) - DW'(req_seg_start_x);
      ay1_ff <= DW'(req_query_y) - DW'(req_seg_start_y);
      sx1_ff <= req_seg_start_x;
      sy1_ff <= req_seg_start_y;
      ex1_ff <= req_seg_end_x;
      ey1_ff <= req_seg_end_y;
   end

   // stage 2: products of differences
   logic              v2_ff, zero2_ff;
   logic signed [PW-1:0] dxx2_ff, dyy2_ff, nx2_ff, ny2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff;
   logic signed [CW-1:0] sx2_ff, sy2_ff, ex2_ff, ey2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      dxx2_ff  <= dx1_ff * dx1_ff;
      dyy2_ff  <= dy1_ff * dy1_ff;
      nx2_ff   <= ax1_ff * dx1_ff;
      ny2_ff   <= ay1_ff * dy1_ff;
      zero2_ff <= (dx1_ff == '0) && (dy1_ff == '0);
      dx2_ff   <= dx1_ff;
      dy2_ff   <= dy1_ff;
      sx2_ff   <= sx1_ff;
      sy2_ff   <= sy1_ff;
      ex2_ff   <= ex1_ff;
      ey2_ff   <= ey1_ff;
   end

   // stage 3: length squared and dot product
   logic              v3_ff, zero3_ff;
   logic signed [LW-1:0] len3_ff, num3_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff;
   logic signed [CW-1:0] sx3_ff, sy3_ff, ex3_ff, ey3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      len3_ff  <= LW'(dxx2_ff) + LW'(dyy2_ff);
      num3_ff  <= LW'(nx2_ff) + LW'(ny2_ff);
      zero3_ff <= zero2_ff;
      dx3_ff   <= dx2_ff;
      dy3_ff   <= dy2_ff;
      sx3_ff   <= sx2_ff;
      sy3_ff   <= sy2_ff;
      ex3_ff   <= ex2_ff;
      ey3_ff   <= ey2_ff;
   end

   // stage 4: clamp decision and numerator products
   cpos_pkg::code_type code_in;
   logic signed [CW-1:0] altx_in, alty_in;

   always_comb begin
      code_in = cpos_pkg::CLAMP_NONE;
      altx_in = sx3_ff;
      alty_in = sy3_ff;
      if (!zero3_ff) begin
         if (num3_ff < 0) begin
            code_in = cpos_pkg::CLAMP_START;
         end else if (num3_ff > len3_ff) begin
            code_in = cpos_pkg::CLAMP_END;
            altx_in = ex3_ff;
            alty_in = ey3_ff;
         end
      end
   end

   logic              v4_ff, zero4_ff, use4_ff;
   cpos_pkg::code_type code4_ff;
   logic signed [CW-1:0] altx4_ff, alty4_ff;
   logic signed [MW-1:0] sxl4_ff, syl4_ff, ndx4_ff, ndy4_ff;
   logic signed [LW-1:0] len4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      code4_ff <= code_in;
      zero4_ff <= zero3_ff;
      use4_ff  <= !zero3_ff && (code_in == cpos_pkg::CLAMP_NONE);
      altx4_ff <= altx_in;
      alty4_ff <= alty_in;
      sxl4_ff  <= MW'(sx3_ff) * MW'(len3_ff);
      syl4_ff  <= MW'(sy3_ff) * MW'(len3_ff);
      ndx4_ff  <= MW'(num3_ff) * MW'(dx3_ff);
      ndy4_ff  <= MW'(num3_ff) * MW'(dy3_ff);
      len4_ff  <= len3_ff;
   end

   // stage 5: numerator sum, split into sign and magnitude
   logic signed [NW-1:0] sumx, sumy;
   assign sumx = NW'(sxl4_ff) + NW'(ndx4_ff);
   assign sumy = NW'(syl4_ff) + NW'(ndy4_ff);

   logic              v5_ff;
   logic [NW-1:0]     magx5_ff, magy5_ff;
   logic [LW-1:0]     den5_ff;
   logic [SW-1:0]     sidex5_ff;
   logic [TW-1:0]     sidey5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      magx5_ff  <= sumx[NW-1] ? NW'(-sumx) : NW'(sumx);
      magy5_ff  <= sumy[NW-1] ? NW'(-sumy) : NW'(sumy);
      // a zero-length or clamped query gets a unit divisor; its quotient is unused
      den5_ff   <= use4_ff ? LW'(len4_ff) : LW'(1);
      sidex5_ff <= {use4_ff, sumx[NW-1], altx4_ff, code4_ff, zero4_ff};
      sidey5_ff <= {sumy[NW-1], alty4_ff};
   end

   // divide, truncating the magnitude
   logic              dv_valid;
   logic [CW-1:0]     qx, qy;
   logic [SW-1:0]     sidex;
   logic [TW-1:0]     sidey;

   cpos_div #(
      .NUM_WIDTH  (NW),
      .DEN_WIDTH  (LW),
      .QUOT_WIDTH (CW),
      .SIDE_WIDTH (SW)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .numer     (magx5_ff),
      .denom     (den5_ff),
      .side_in   (sidex5_ff),
      .out_valid (dv_valid),
      .quot      (qx),
      .side_out  (sidex)
   );

   cpos_div #(
      .NUM_WIDTH  (NW),
      .DEN_WIDTH  (LW),
      .QUOT_WIDTH (CW),
      .SIDE_WIDTH (TW)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .numer     (magy5_ff),
      .denom     (den5_ff),
      .side_in   (sidey5_ff),
      .out_valid (),
      .quot      (qy),
      .side_out  (sidey)
   );

   // output stage: restore sign, choose projection or endpoint
   logic              d_use, d_negx, d_negy, d_zero;
   logic signed [CW-1:0] d_altx, d_alty;
   cpos_pkg::code_type d_code;

   assign {d_use, d_negx, d_altx, d_code, d_zero} = sidex;
   assign {d_negy, d_alty} = sidey;

   logic              strobe_ff, zero_ff;
   logic signed [CW-1:0] nx_ff, ny_ff;
   cpos_pkg::code_type code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid;
      end
      nx_ff   <= d_use ? (d_negx ? CW'(-qx) : CW'(qx)) : d_altx;
      ny_ff   <= d_use ? (d_negy ? CW'(-qy) : CW'(qy)) : d_alty;
      code_ff <= d_code;
      zero_ff <= d_zero;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_near_x      = nx_ff;
   assign rsp_near_y      = ny_ff;
   assign rsp_clamp_code  = code_ff;
   assign rsp_zero_length = zero_ff;

endmodule

[tb/closest_point_on_segment_unit_checker.sv]
// ----------------------------------------------------------------------------
// Closest point on segment checker
// Watches the query and result channels, predicts the nearest point for each
// accepted query and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module closest_point_on_segment_unit_checker #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_query_x,
   input  logic signed [COORD_WIDTH-1:0] req_query_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic                          rsp_strobe,
   input  logic signed [COORD_WIDTH-1:0] rsp_near_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_near_y,
   input  cpos_pkg::code_type            rsp_clamp_code,
   input  logic                          rsp_zero_length,
   output int                            fail_count,
   output int                            pending_count,
   output int                            result_count
);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] near_x;
      logic signed [COORD_WIDTH-1:0] near_y;
      cpos_pkg::code_type            clamp_code;
      logic                          zero_length;
   } nearest_type;

   nearest_type nearest_queue[$];

   // saturate a wide value to the coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] clip_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[COORD_WIDTH-1:0];
   endfunction

   // project the query onto the segment, clamp to the nearer endpoint
   function automatic nearest_type predict_nearest(longint qx, longint qy, longint sx,
                                                   longint sy, longint ex, longint ey);
      nearest_type r;
      longint   dx;
      longint   dy;
      longint   len_sq;
      longint   dot;
      longint   px;
      longint   py;
      dx = ex - sx;
      dy = ey - sy;
      px = sx;
      py = sy;
      r.clamp_code  = cpos_pkg::CLAMP_NONE;
      r.zero_length = 1'b0;
      if (dx == 0 && dy == 0) begin
         r.zero_length = 1'b1;
      end else begin
         len_sq = dx * dx + dy * dy;
         dot    = (qx - sx) * dx + (qy - sy) * dy;
         if (dot < 0) begin
            r.clamp_code = cpos_pkg::CLAMP_START;
         end else if (dot > len_sq) begin
            r.clamp_code = cpos_pkg::CLAMP_END;
            px = ex;
            py = ey;
         end else begin
            px = (sx * len_sq + dot * dx) / len_sq;
            py = (sy * len_sq + dot * dy) / len_sq;
         end
      end
      r.near_x = clip_coord(px);
      r.near_y = clip_coord(py);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch on result %0d: %s got %0d expected %0d",
               $realtime, result_count, what, got, want);
      fail_count++;
   endtask

   assign pending_count = nearest_queue.size();

   // predict on accepted queries, compare on strobes
   always @(posedge clock) begin
      nearest_type want;
      if (reset) begin
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (start && !busy)
            nearest_queue.push_back(predict_nearest(req_query_x, req_query_y,
               req_seg_start_x, req_seg_start_y, req_seg_end_x, req_seg_end_y));
         if (rsp_strobe) begin
            if (nearest_queue.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = nearest_queue.pop_front();
               if (rsp_near_x !== want.near_x)
                  report_mismatch("near_x", rsp_near_x, want.near_x);
               if (rsp_near_y !== want.near_y)
                  report_mismatch("near_y", rsp_near_y, want.near_y);
               if (rsp_clamp_code !== want.clamp_code)
                  report_mismatch("clamp_code", rsp_clamp_code, want.clamp_code);
               if (rsp_zero_length !== want.zero_length)
                  report_mismatch("zero_length", rsp_zero_length, want.zero_length);
            end
            result_count <= result_count + 1;
         end
      end
   end

endmodule

[tb/closest_point_on_segment_unit_tb.sv]
// ----------------------------------------------------------------------------
// Closest point on segment testbench
// Drives directed corner queries and then random segments and query points
// under varying sender gaps; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module closest_point_on_segment_unit_tb;

   localparam int CW        = 20;
   localparam int LATENCY   = 6 + CW;
   localparam int WATCHDOG  = 2000;
   localparam int N_RANDOM  = 1730;
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [CW-1:0] req_query_x, req_query_y;
   logic signed [CW-1:0] req_seg_start_x, req_seg_start_y;
   logic signed [CW-1:0] req_seg_end_x, req_seg_end_y;
   logic                 rsp_strobe;
   logic signed [CW-1:0] rsp_near_x, rsp_near_y;
   cpos_pkg::code_type   rsp_clamp_code;
   logic                 rsp_zero_length;
   int                   fail_count, pending_count, result_count;
   int                   idle_pct;
   int                   quiet_cycles;
   int                   query_count;

   closest_point_on_segment_unit #(.COORD_WIDTH(CW), .FRAC_BITS(8)) i_dut (.*);

   closest_point_on_segment_unit_checker #(.COORD_WIDTH(CW)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // offer one query word, idle at random first, hold until accepted
   task automatic send_query(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                             logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                             logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_query_x     <= qx;
      req_query_y     <= qy;
      req_seg_start_x <= sx;
      req_seg_start_y <= sy;
      req_seg_end_x   <= ex;
      req_seg_end_y   <= ey;
      @(posedge clock);
      while (busy) @(posedge clock);
      query_count++;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int span);
      if (span >= CW) return CW'($urandom());
      return CW'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
   endfunction

   // random segment with a query near it, sometimes degenerate or wide
   task automatic send_random();
      logic signed [CW-1:0] sx, sy, ex, ey, qx, qy;
      int span;
      int shape;
      span  = $urandom_range(4, CW);
      shape = $urandom_range(9);
      sx = rand_coord(span);
      sy = rand_coord(span);
      ex = rand_coord(span);
      ey = rand_coord(span);
      qx = rand_coord(span);
      qy = rand_coord(span);
      case (shape)
         0: begin ex = sx; end
         1: begin ey = sy; end
         2: begin ex = sx; ey = sy; end
         3: begin
            sx = CW'($urandom()); sy = CW'($urandom());
            ex = CW'($urandom()); ey = CW'($urandom());
            qx = CW'($urandom()); qy = CW'($urandom());
         end
         default: ;
      endcase
      send_query(qx, qy, sx, sy, ex, ey);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_query_x     = '0;
      req_query_y     = '0;
      req_seg_start_x = '0;
      req_seg_start_y = '0;
      req_seg_end_x   = '0;
      req_seg_end_y   = '0;
      quiet_cycles    = 0;
      query_count     = 0;
      idle_pct        = 9;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: extremes, vertical, horizontal, zero length, endpoints
      send_query(0, 0, 0, 0, 0, 0);
      send_query(C_MAX, C_MIN, 5, -7, 5, -7);
      send_query(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
      send_query(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
      send_query(0, 0, C_MIN, C_MIN, C_MAX, C_MAX);
      send_query(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
      send_query(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
      send_query(100, -500, 0, 0, 0, 256);
      send_query(100, 900, 0, 0, 0, 256);
      send_query(100, 128, 0, 0, 0, 256);
      send_query(-300, 40, 0, 0, 256, 0);
      send_query(900, 40, 0, 0, 256, 0);
      send_query(77, 40, 0, 0, 256, 0);
      send_query(0, 0, 0, 0, 256, 256);
      send_query(256, 256, 0, 0, 256, 256);
      send_query(1, 0, 0, 0, 3, 3);
      send_query(-1, 0, 0, 0, -3, -3);
      send_query(C_MAX, C_MAX, 0, C_MIN, 0, C_MAX);
      send_query(C_MIN, 0, C_MIN, 0, C_MAX, 0);
      send_query(10, 20, 30, -40, -50, 60);
      send_query(-12345, 23456, 1000, 1000, -1000, 3000);

      // random: sender gaps, then none
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) idle_pct = 78;
         if (i == 2 * N_RANDOM / 3) idle_pct = 0;
         send_random();
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Covered %0d queries and %0d result words, including zero-length,",
               query_count, result_count);
      $display("axis-aligned, clamped and full-range segments.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
